// ===== rtl/swu_pkg.sv =====
// Shared types, constants and the decay table function of the STDP weight update block.
package swu_pkg;

   localparam int SYNAPSES_DEFAULT          = 1024;
   localparam int EXP_TABLE_ENTRIES_DEFAULT = 64;

   localparam int SYN_W     = 10;
   localparam int TIME_W    = 32;
   localparam int WEIGHT_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam int QUEUE_DEPTH = 2;

   localparam logic REQ_EVENT = 1'b0;
   localparam logic REQ_LOAD  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POT_AMPLITUDE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEP_AMPLITUDE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POT_DECAY_RATE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEP_DECAY_RATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_CEILING = 3'd4;

   localparam logic [15:0] POT_AMPLITUDE_RESET  = 16'd1638;
   localparam logic [15:0] DEP_AMPLITUDE_RESET  = 16'd1638;
   localparam logic [15:0] POT_DECAY_RATE_RESET = 16'd295;
   localparam logic [15:0] DEP_DECAY_RATE_RESET = 16'd295;
   localparam logic [15:0] WEIGHT_CEILING_RESET = 16'd16384;

   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam logic [63:0] HALF_POWERS [8] = '{
      64'd3037000500, 64'd3611622603, 64'd3938502376, 64'd4112874773,
      64'd4202935003, 64'd4248701965, 64'd4271771996, 64'd4283353945
   };

   typedef struct packed {
      logic [15:0] pot_amplitude;
      logic [15:0] dep_amplitude;
      logic [15:0] pot_decay_rate;
      logic [15:0] dep_decay_rate;
      logic [15:0] weight_ceiling;
   } cfg_type;

   typedef struct packed {
      logic                is_load;
      logic                potentiate;
      logic [SYN_W-1:0]    synapse;
      logic [SYN_W-1:0]    quotient;
      logic [TIME_W-1:0]   magnitude;
      logic [WEIGHT_W-1:0] load_weight;
   } queue_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_IDX,
      BK_TBL,
      BK_STEP,
      BK_WB
   } back_state_type;

   // Evaluates 2^(-e/65536) in Q1.16; used only to build constant tables.
   function automatic logic [16:0] exp2_neg_frac(input logic [15:0] e);
      logic [63:0] acc;
      logic [63:0] r;
      logic [63:0] y;
      logic [63:0] low;
      logic [63:0] rounded;
      acc = 64'd1 << 32;
      for (int i = 0; i < 8; i++) begin
         if (e[15-i]) begin
            acc = (acc * HALF_POWERS[i] + (64'd1 << 31)) >> 32;
         end
      end
      r = {56'd0, e[7:0]};
      if (r != 64'd0) begin
         y   = (r * LN2_Q32) >> 16;
         low = (64'd1 << 32) - y + ((y * y) >> 33);
         acc = (acc * low + (64'd1 << 31)) >> 32;
      end
      rounded = (acc + (64'd1 << 15)) >> 16;
      return rounded[16:0];
   endfunction

endpackage

// ===== rtl/stdp_weight_update.sv =====
// Top level of the STDP weight update block: configuration registers, front end, queue, engine.
// A load passes the engine's multiply and write-back states; a plasticity event also passes
// its index, table and step states between them, then strobes its result from a register.
// A two-entry queue takes new transactions meanwhile; busy is high while it is full.
// Results are strobed on rsp_valid for one cycle each; the receiver cannot stall them.
// Synchronous reset restores the register defaults; the weight memory is not cleared.
module stdp_weight_update #(
   parameter int SYNAPSES          = swu_pkg::SYNAPSES_DEFAULT,
   parameter int EXP_TABLE_ENTRIES = swu_pkg::EXP_TABLE_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [swu_pkg::SYN_W-1:0]      req_synapse_index,
   input  logic [swu_pkg::TIME_W-1:0]     req_post_spike_time,
   input  logic [swu_pkg::TIME_W-1:0]     req_pre_release_time,
   input  logic [swu_pkg::WEIGHT_W-1:0]   req_load_weight,
   output logic                           rsp_valid,
   output logic [swu_pkg::SYN_W-1:0]      rsp_out_synapse,
   output logic [swu_pkg::WEIGHT_W-1:0]   rsp_new_weight,
   output logic                           rsp_potentiated,
   output logic                           rsp_clamped,
   input  logic                           csr_write_enable,
   input  logic [swu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swu_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import swu_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   queue_entry_type front_entry;
   queue_entry_type head;
   logic            push;
   logic            pop;
   logic            empty;
   logic            full;

   assign busy = full;
   assign push = start && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POT_AMPLITUDE:  cfg_in.pot_amplitude  = csr_wdata;
            CSR_DEP_AMPLITUDE:  cfg_in.dep_amplitude  = csr_wdata;
            CSR_POT_DECAY_RATE: cfg_in.pot_decay_rate = csr_wdata;
            CSR_DEP_DECAY_RATE: cfg_in.dep_decay_rate = csr_wdata;
            CSR_WEIGHT_CEILING: cfg_in.weight_ceiling = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pot_amplitude  <= POT_AMPLITUDE_RESET;
         cfg_ff.dep_amplitude  <= DEP_AMPLITUDE_RESET;
         cfg_ff.pot_decay_rate <= POT_DECAY_RATE_RESET;
         cfg_ff.dep_decay_rate <= DEP_DECAY_RATE_RESET;
         cfg_ff.weight_ceiling <= WEIGHT_CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swu_front #(
      .SYNAPSES (SYNAPSES)
   ) u_front (
      .req_type             (req_type),
      .req_synapse_index    (req_synapse_index),
      .req_post_spike_time  (req_post_spike_time),
      .req_pre_release_time (req_pre_release_time),
      .req_load_weight      (req_load_weight),
      .entry                (front_entry)
   );

   swu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   swu_back #(
      .SYNAPSES          (SYNAPSES),
      .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_out_synapse (rsp_out_synapse),
      .rsp_new_weight  (rsp_new_weight),
      .rsp_potentiated (rsp_potentiated),
      .rsp_clamped     (rsp_clamped)
   );

endmodule

// ===== rtl/swu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module swu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swu_front.sv =====
// Front end: forms the time difference, classifies each transaction and pre-reduces its index.
module swu_front #(
   parameter int SYNAPSES = swu_pkg::SYNAPSES_DEFAULT
) (
   input  logic                          req_type,
   input  logic [swu_pkg::SYN_W-1:0]     req_synapse_index,
   input  logic [swu_pkg::TIME_W-1:0]    req_post_spike_time,
   input  logic [swu_pkg::TIME_W-1:0]    req_pre_release_time,
   input  logic [swu_pkg::WEIGHT_W-1:0]  req_load_weight,
   output swu_pkg::queue_entry_type      entry
);
   import swu_pkg::*;

   localparam logic [19:0] RECIP = 20'((1 << 20) / SYNAPSES);

   logic [TIME_W-1:0] diff;
   logic [29:0]       quot_prod;

   assign diff      = req_post_spike_time - req_pre_release_time;
   assign quot_prod = {20'd0, req_synapse_index} * {10'd0, RECIP};

   always_comb begin
      entry.is_load     = (req_type == REQ_LOAD);
      entry.potentiate  = ~diff[TIME_W-1];
      entry.synapse     = req_synapse_index;
      entry.quotient    = quot_prod[29:20];
      entry.magnitude   = diff[TIME_W-1] ? (TIME_W'(0) - diff) : diff;
      entry.load_weight = req_load_weight;
   end

endmodule

// ===== rtl/swu_queue.sv =====
// Short register queue that decouples the front end from the update engine.
module swu_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  swu_pkg::queue_entry_type push_entry,
   input  logic                     pop,
   output swu_pkg::queue_entry_type head,
   output logic                     empty,
   output logic                     full
);
   import swu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type  slots [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : ptr + PTR_W'(1);
   endfunction

   assign empty = (count_ff == CNT_W'(0));
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head  = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/swu_back.sv =====
// Update engine: decay factor, weight read-modify-write and the result register.
module swu_back #(
   parameter int SYNAPSES          = swu_pkg::SYNAPSES_DEFAULT,
   parameter int EXP_TABLE_ENTRIES = swu_pkg::EXP_TABLE_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swu_pkg::cfg_type              cfg,
   input  swu_pkg::queue_entry_type      head,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [swu_pkg::SYN_W-1:0]     rsp_out_synapse,
   output logic [swu_pkg::WEIGHT_W-1:0]  rsp_new_weight,
   output logic                          rsp_potentiated,
   output logic                          rsp_clamped
);
   import swu_pkg::*;

   localparam int AW = $clog2(SYNAPSES);
   localparam int KW = $clog2(EXP_TABLE_ENTRIES);
   localparam logic [26:0] SYN_C = 27'(SYNAPSES);
   localparam logic [26:0] ENT_C = 27'(EXP_TABLE_ENTRIES);

   back_state_type      state_ff, state_in;
   queue_entry_type     item_ff;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [47:0]         p_ff, p_in;
   logic                zero_ff;
   logic [3:0]          shift_ff;
   logic [KW-1:0]       k_ff, k_in;
   logic [16:0]         tbl_ff;
   logic [WEIGHT_W-1:0] step_ff, step_in;

   logic                rsp_valid_ff;
   logic [SYN_W-1:0]    rsp_synapse_ff;
   logic [WEIGHT_W-1:0] rsp_weight_ff;
   logic                rsp_pot_ff;
   logic                rsp_clamp_ff;

   logic                rd_en;
   logic                wb;
   logic [WEIGHT_W-1:0] weight;
   logic [15:0]         amplitude;
   logic [15:0]         rate;
   logic [26:0]         residue_raw;
   logic [26:0]         residue;
   logic [26:0]         k_prod;
   logic [16:0]         factor;
   logic [32:0]         amp_prod;
   logic [16:0]         sum;
   logic [WEIGHT_W-1:0] w_new;
   logic                clamp_new;
   logic                pot_new;

   logic [16:0] frac_table [EXP_TABLE_ENTRIES];

   for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_table
      localparam logic [15:0] EXPONENT = 16'((g * 65536) / EXP_TABLE_ENTRIES);
      assign frac_table[g] = exp2_neg_frac(EXPONENT);
   end

   swu_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (SYNAPSES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wb),
      .wr_addr (addr_ff),
      .wr_data (w_new),
      .rd_en   (rd_en),
      .rd_addr (addr_in),
      .rd_data (weight)
   );

   assign amplitude   = item_ff.potentiate ? cfg.pot_amplitude : cfg.dep_amplitude;
   assign rate        = item_ff.potentiate ? cfg.pot_decay_rate : cfg.dep_decay_rate;
   assign residue_raw = {17'd0, item_ff.synapse} - ({17'd0, item_ff.quotient} * SYN_C);
   assign residue     = (residue_raw >= SYN_C) ? residue_raw - SYN_C : residue_raw;
   assign addr_in     = residue[AW-1:0];
   assign p_in        = {16'd0, item_ff.magnitude} * {32'd0, rate};
   assign k_prod      = {11'd0, p_ff[15:0]} * ENT_C;
   assign k_in        = k_prod[16 +: KW];
   assign factor      = tbl_ff >> shift_ff;
   assign amp_prod    = {17'd0, amplitude} * {16'd0, factor};
   assign step_in     = zero_ff ? '0 : amp_prod[31:16];
   assign sum         = {1'b0, weight} + {1'b0, step_ff};

   always_comb begin
      w_new     = item_ff.load_weight;
      clamp_new = 1'b0;
      pot_new   = 1'b0;
      if (!item_ff.is_load) begin
         if (item_ff.potentiate) begin
            pot_new = 1'b1;
            if (sum > {1'b0, cfg.weight_ceiling}) begin
               w_new     = cfg.weight_ceiling;
               clamp_new = 1'b1;
            end else begin
               w_new = sum[WEIGHT_W-1:0];
            end
         end else if (step_ff > weight) begin
            w_new     = '0;
            clamp_new = 1'b1;
         end else begin
            w_new = weight - step_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      rd_en    = 1'b0;
      wb       = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            rd_en    = 1'b1;
            state_in = item_ff.is_load ? BK_WB : BK_IDX;
         end
         BK_IDX: begin
            state_in = BK_TBL;
         end
         BK_TBL: begin
            state_in = BK_STEP;
         end
         BK_STEP: begin
            state_in = BK_WB;
         end
         BK_WB: begin
            wb = 1'b1;
            if (!empty) begin
               pop      = 1'b1;
               state_in = BK_MUL;
            end else begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= wb;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head;
      end
      addr_ff  <= addr_in;
      p_ff     <= p_in;
      zero_ff  <= |p_ff[47:20];
      shift_ff <= p_ff[19:16];
      k_ff     <= k_in;
      tbl_ff   <= frac_table[k_ff];
      step_ff  <= step_in;
      if (wb) begin
         rsp_synapse_ff <= item_ff.synapse;
         rsp_weight_ff  <= w_new;
         rsp_pot_ff     <= pot_new;
         rsp_clamp_ff   <= clamp_new;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_synapse = rsp_synapse_ff;
   assign rsp_new_weight  = rsp_weight_ff;
   assign rsp_potentiated = rsp_pot_ff;
   assign rsp_clamped     = rsp_clamp_ff;

endmodule

// ===== rtl/swu_checker.sv =====
// Port-level checker for the STDP weight update block, with its bind statement.
module swu_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [15:0] rsp_new_weight,
   input logic        rsp_potentiated,
   input logic        rsp_clamped
);

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("result strobe or busy seen straight after reset");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in two consecutive cycles");

   a_depress_floor : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clamped && !rsp_potentiated) |-> (rsp_new_weight == 16'd0))
      else $error("clamped depression did not give a zero weight");

endmodule

bind stdp_weight_update swu_checker u_swu_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_new_weight  (rsp_new_weight),
   .rsp_potentiated (rsp_potentiated),
   .rsp_clamped     (rsp_clamped)
);

// ===== dv/tb.sv =====
// Self-checking testbench of the STDP weight update block: directed table, then random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swu_pkg::*;

   localparam int HALF_PERIOD     = 2;
   localparam int SYNAPSES        = SYNAPSES_DEFAULT;
   localparam int EXP_ENTRIES     = EXP_TABLE_ENTRIES_DEFAULT;
   localparam int REGISTERS       = int'(CSR_WEIGHT_CEILING) + 1;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 308;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 300000;

   localparam logic [63:0] LN2_FRAC = 64'd2977044472;
   localparam logic [63:0] ROOT_Q32 [8] = '{
      64'd3037000500, 64'd3611622603, 64'd3938502376, 64'd4112874773,
      64'd4202935003, 64'd4248701965, 64'd4271771996, 64'd4283353945
   };

   typedef struct packed {
      logic                kind;
      logic [SYN_W-1:0]    synapse;
      logic [TIME_W-1:0]   post_time;
      logic [TIME_W-1:0]   pre_time;
      logic [WEIGHT_W-1:0] load_value;
   } plasticity_req_type;

   typedef struct packed {
      logic [SYN_W-1:0]    synapse;
      logic [WEIGHT_W-1:0] weight;
      logic                potentiated;
      logic                clamped;
   } weight_result_type;

   typedef struct packed {
      logic               known;
      plasticity_req_type req;
      weight_result_type  result;
   } stimulus_row_type;

   logic                 clock                = 1'b0;
   logic                 reset                = 1'b1;
   logic                 start                = 1'b0;
   logic                 busy;
   logic                 req_type             = REQ_EVENT;
   logic [SYN_W-1:0]     req_synapse_index    = '0;
   logic [TIME_W-1:0]    req_post_spike_time  = '0;
   logic [TIME_W-1:0]    req_pre_release_time = '0;
   logic [WEIGHT_W-1:0]  req_load_weight      = '0;
   logic                 rsp_valid;
   logic [SYN_W-1:0]     rsp_out_synapse;
   logic [WEIGHT_W-1:0]  rsp_new_weight;
   logic                 rsp_potentiated;
   logic                 rsp_clamped;
   logic                 csr_write_enable     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index            = '0;
   logic [CSR_DAT_W-1:0] csr_wdata            = '0;

   logic [CSR_DAT_W-1:0] csr_shadow [REGISTERS];
   logic [16:0]          pow2_frac [EXP_ENTRIES];
   logic [WEIGHT_W-1:0]  weight_model [SYNAPSES];
   bit                   weight_loaded [SYNAPSES];
   int unsigned          loaded_list [$];
   logic [SYN_W-1:0]     last_synapse = '0;
   weight_result_type    weights_due [$];
   stimulus_row_type     directed [$];
   int                   idle_pct     = 0;
   int                   mismatches   = 0;
   int                   cycle_count  = 0;

   stdp_weight_update i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_synapse_index    (req_synapse_index),
      .req_post_spike_time  (req_post_spike_time),
      .req_pre_release_time (req_pre_release_time),
      .req_load_weight      (req_load_weight),
      .rsp_valid            (rsp_valid),
      .rsp_out_synapse      (rsp_out_synapse),
      .rsp_new_weight       (rsp_new_weight),
      .rsp_potentiated      (rsp_potentiated),
      .rsp_clamped          (rsp_clamped),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [16:0] pow2_neg_q16(input logic [15:0] e);
      logic [63:0] acc;
      logic [63:0] r;
      logic [63:0] y;
      logic [63:0] poly;
      acc = 64'd1 << 32;
      for (int b = 0; b < 8; b++) begin
         if (e[15-b]) begin
            acc = (acc * ROOT_Q32[b] + (64'd1 << 31)) >> 32;
         end
      end
      r = 64'(e[7:0]);
      if (r != 64'd0) begin
         y    = (r * LN2_FRAC) >> 16;
         poly = (64'd1 << 32) - y + ((y * y) >> 33);
         acc  = (acc * poly + (64'd1 << 31)) >> 32;
      end
      acc = (acc + (64'd1 << 15)) >> 16;
      return acc[16:0];
   endfunction

   function automatic logic [31:0] decay_step(input logic [15:0] amp, input logic [15:0] rate,
                                              input logic [32:0] mag);
      logic [63:0] prod;
      logic [63:0] shift;
      logic [63:0] slot;
      logic [63:0] factor;
      prod  = 64'(mag) * 64'(rate);
      shift = prod >> 16;
      if (shift >= 64'd16) begin
         return 32'd0;
      end
      slot   = ((prod & 64'hFFFF) * EXP_ENTRIES) >> 16;
      factor = 64'(pow2_frac[slot]) >> shift;
      prod   = (64'(amp) * factor) >> 16;
      return prod[31:0];
   endfunction

   function automatic weight_result_type update_weight(input plasticity_req_type req);
      weight_result_type res;
      logic [31:0]       dt;
      logic [31:0]       level;
      logic [31:0]       change;
      int unsigned       slot;
      slot        = req.synapse % SYNAPSES;
      res         = '0;
      res.synapse = req.synapse;
      if (req.kind == REQ_LOAD) begin
         level = 32'(req.load_value);
         if (!weight_loaded[slot]) begin
            weight_loaded[slot] = 1'b1;
            loaded_list.push_back(slot);
         end
      end else begin
         dt    = req.post_time - req.pre_time;
         level = 32'(weight_model[slot]);
         if (!dt[31]) begin
            res.potentiated = 1'b1;
            level = level + decay_step(csr_shadow[CSR_POT_AMPLITUDE],
                                       csr_shadow[CSR_POT_DECAY_RATE], {1'b0, dt});
            if (level > 32'(csr_shadow[CSR_WEIGHT_CEILING])) begin
               level       = 32'(csr_shadow[CSR_WEIGHT_CEILING]);
               res.clamped = 1'b1;
            end
         end else begin
            change = decay_step(csr_shadow[CSR_DEP_AMPLITUDE], csr_shadow[CSR_DEP_DECAY_RATE],
                                33'h1_0000_0000 - {1'b0, dt});
            if (change > level) begin
               level       = 32'd0;
               res.clamped = 1'b1;
            end else begin
               level = level - change;
            end
         end
      end
      weight_model[slot] = level[15:0];
      res.weight         = level[15:0];
      return res;
   endfunction

   function automatic plasticity_req_type draw_request();
      plasticity_req_type req;
      logic [31:0]        gap;
      int unsigned        roll;
      req.post_time  = $urandom();
      req.load_value = WEIGHT_W'($urandom());
      gap            = 32'd0;
      if (loaded_list.size() == 0 || $urandom_range(99) < 15) begin
         req.kind = REQ_LOAD;
         if ($urandom_range(1) == 1) begin
            req.synapse = SYN_W'($urandom_range(SYNAPSES - 1));
         end else begin
            req.synapse = SYN_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
         end
         if ($urandom_range(99) < 30) begin
            req.load_value = csr_shadow[CSR_WEIGHT_CEILING] - WEIGHT_W'($urandom_range(2000));
         end
      end else begin
         req.kind = REQ_EVENT;
         if ($urandom_range(99) < 40) begin
            req.synapse = last_synapse;
         end else begin
            req.synapse = SYN_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
         end
         roll = $urandom_range(99);
         if (roll < 20) begin
            gap = $urandom_range(63);
         end else if (roll < 75) begin
            gap = $urandom_range(4095);
         end else if (roll < 88) begin
            gap = $urandom();
         end else begin
            case ($urandom_range(3))
               0: gap = 32'h0000_0000;
               1: gap = 32'h0000_0001;
               2: gap = 32'h7FFF_FFFF;
               default: gap = 32'h8000_0000;
            endcase
         end
         if ($urandom_range(1) == 1) begin
            gap = -gap;
         end
      end
      req.pre_time = req.post_time - gap;
      last_synapse = req.synapse;
      return req;
   endfunction

   function automatic stimulus_row_type row(input bit known, input logic kind, input int syn,
                                            input logic [31:0] post_time,
                                            input logic [31:0] pre_time, input int ld,
                                            input int w, input bit pot, input bit clamp);
      stimulus_row_type r;
      r.known              = known;
      r.req.kind           = kind;
      r.req.synapse        = SYN_W'(syn);
      r.req.post_time      = post_time;
      r.req.pre_time       = pre_time;
      r.req.load_value     = WEIGHT_W'(ld);
      r.result.synapse     = SYN_W'(syn);
      r.result.weight      = WEIGHT_W'(w);
      r.result.potentiated = pot;
      r.result.clamped     = clamp;
      return r;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_request(input plasticity_req_type req, input bit known,
                               input weight_result_type known_result);
      weight_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start                <= 1'b1;
      req_type             <= req.kind;
      req_synapse_index    <= req.synapse;
      req_post_spike_time  <= req.post_time;
      req_pre_release_time <= req.pre_time;
      req_load_weight      <= req.load_value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      predicted = update_weight(req);
      weights_due.push_back(known ? known_result : predicted);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      if (idx < REGISTERS) begin
         csr_shadow[idx] = data;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin : check_results
      weight_result_type want;
      if (!reset && rsp_valid) begin
         if (weights_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual synapse %0d weight %0d",
                     $time, rsp_out_synapse, rsp_new_weight);
            mismatches++;
         end else begin
            want = weights_due.pop_front();
            check_field("out_synapse", 32'(want.synapse), 32'(rsp_out_synapse));
            check_field("new_weight", 32'(want.weight), 32'(rsp_new_weight));
            check_field("potentiated", 32'(want.potentiated), 32'(rsp_potentiated));
            check_field("clamped", 32'(want.clamped), 32'(rsp_clamped));
         end
      end
   end

   initial begin
      logic [CSR_DAT_W-1:0] settings [REGISTERS];
      for (int k = 0; k < EXP_ENTRIES; k++) begin
         pow2_frac[k] = pow2_neg_q16(16'((k << 16) / EXP_ENTRIES));
      end
      for (int k = 0; k < SYNAPSES; k++) begin
         weight_model[k]  = '0;
         weight_loaded[k] = 1'b0;
      end
      csr_shadow[CSR_POT_AMPLITUDE]  = POT_AMPLITUDE_RESET;
      csr_shadow[CSR_DEP_AMPLITUDE]  = DEP_AMPLITUDE_RESET;
      csr_shadow[CSR_POT_DECAY_RATE] = POT_DECAY_RATE_RESET;
      csr_shadow[CSR_DEP_DECAY_RATE] = DEP_DECAY_RATE_RESET;
      csr_shadow[CSR_WEIGHT_CEILING] = WEIGHT_CEILING_RESET;

      directed.push_back(row(1, REQ_LOAD, 0, 32'h0, 32'h0, 0, 0, 0, 0));
      directed.push_back(row(1, REQ_LOAD, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65535, 65535, 0,
                             0));
      directed.push_back(row(1, REQ_LOAD, 341, 32'h5555_5555, 32'hAAAA_AAAA, 'h5555, 'h5555,
                             0, 0));
      directed.push_back(row(1, REQ_LOAD, 682, 32'hAAAA_AAAA, 32'h5555_5555, 'hAAAA, 'hAAAA,
                             0, 0));
      directed.push_back(row(1, REQ_LOAD, 1, 32'h0, 32'h0, 100, 100, 0, 0));
      directed.push_back(row(1, REQ_EVENT, 1, 32'd1000, 32'd1000, 0, 1738, 1, 0));
      directed.push_back(row(1, REQ_EVENT, 0, 32'h7FFF_FFFF, 32'h0, 0, 0, 1, 0));
      directed.push_back(row(1, REQ_EVENT, 0, 32'h0, 32'h8000_0000, 0, 0, 0, 0));
      directed.push_back(row(1, REQ_EVENT, 0, 32'h0, 32'h1, 0, 0, 0, 1));
      directed.push_back(row(1, REQ_EVENT, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16384, 1, 1));
      directed.push_back(row(0, REQ_EVENT, 1023, 32'h5, 32'hFFFF_FFFB, 0, 0, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 341, 32'd100, 32'd200, 0, 0, 0, 0));
      directed.push_back(row(1, REQ_EVENT, 682, 32'hFFFF_FFFF, 32'h0, 0, 42052, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 341, 32'h0, 32'h7FFF_FFFF, 0, 0, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 682, 32'd3555, 32'h0, 0, 0, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 682, 32'd3554, 32'h0, 0, 0, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 1, 32'h0, 32'd3554, 0, 0, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 1, 32'h1, 32'h0, 0, 0, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 1, 32'h1, 32'h0, 0, 0, 0, 0));
      directed.push_back(row(0, REQ_EVENT, 1, 32'h0, 32'h1, 0, 0, 0, 0));
      directed.push_back(row(1, REQ_LOAD, 1, 32'h0, 32'h0, 16384, 16384, 0, 0));
      directed.push_back(row(1, REQ_EVENT, 1, 32'h0, 32'h0, 0, 16384, 1, 1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_request(directed[i].req, directed[i].known, directed[i].result);
      end
      start <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         while (weights_due.size() != 0) begin
            @(posedge clock);
         end
         case (phase)
            0: settings = '{POT_AMPLITUDE_RESET, DEP_AMPLITUDE_RESET, POT_DECAY_RATE_RESET,
                            DEP_DECAY_RATE_RESET, WEIGHT_CEILING_RESET};
            1: settings = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
            2: settings = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3: settings = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000};
            4: settings = '{16'($urandom()), 16'($urandom()), 16'($urandom_range(1, 2000)),
                            16'($urandom_range(1, 2000)), 16'($urandom())};
            default: settings = '{16'($urandom()), 16'($urandom()), 16'($urandom()),
                                  16'($urandom()), 16'($urandom())};
         endcase
         for (int r = 0; r < REGISTERS; r++) begin
            write_csr(CSR_IDX_W'(r), settings[r]);
         end
         for (int r = REGISTERS; r < 2 ** CSR_IDX_W; r++) begin
            write_csr(CSR_IDX_W'(r), CSR_DAT_W'($urandom()));
         end
         csr_write_enable <= 1'b0;
         case (phase % 4)
            1: idle_pct = 62;
            3: idle_pct = 19;
            default: idle_pct = 0;
         endcase
         repeat (ITEMS_PER_PHASE) begin
            send_request(draw_request(), 1'b0, '0);
         end
         start <= 1'b0;
      end

      while (weights_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
